@@ design/sfpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfpq_pkg
// Shared types, codes and default sizes of the sorted frequency queue.
// ----------------------------------------------------------------------------
package sfpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SYMBOL_BITS_DEF = 9;
    localparam int FREQ_BITS_DEF   = 24;

    // Operation carried in the kind field of an input beat.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage
`default_nettype wire

@@ design/sfpq_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfpq_in_if
// Request channel: insert or remove, with the entry to insert.
// ----------------------------------------------------------------------------
interface sfpq_in_if #(
    parameter int SYMBOL_BITS = 9,
    parameter int FREQ_BITS   = 24
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [SYMBOL_BITS-1:0] new_symbol;
    logic [FREQ_BITS-1:0]   new_frequency;

    modport source (output valid, kind, new_symbol, new_frequency, input ready);
    modport sink   (input valid, kind, new_symbol, new_frequency, output ready);
endinterface
`default_nettype wire

@@ design/sfpq_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfpq_out_if
// Result channel: status, removed entry and fill state.
// ----------------------------------------------------------------------------
interface sfpq_out_if #(
    parameter int SYMBOL_BITS = 9,
    parameter int FREQ_BITS   = 24,
    parameter int COUNT_BITS  = 5
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [SYMBOL_BITS-1:0] out_symbol;
    logic [FREQ_BITS-1:0]   out_frequency;
    logic [COUNT_BITS-1:0]  entry_count;
    logic                   list_empty;

    modport source (output valid, status, out_symbol, out_frequency, entry_count,
                    list_empty, input ready);
    modport sink   (input valid, status, out_symbol, out_frequency, entry_count,
                    list_empty, output ready);
endinterface
`default_nettype wire

@@ design/sfpq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfpq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// and left on remove.
// ----------------------------------------------------------------------------
module sfpq_cell #(
    parameter int SYMBOL_BITS = 9,
    parameter int FREQ_BITS   = 24
) (
    input  wire                   i_clk,
    input  wire sfpq_pkg::t_cell_cmd i_cmd,
    input  wire                   i_occ,
    input  wire [SYMBOL_BITS-1:0] i_new_sym,
    input  wire [FREQ_BITS-1:0]   i_new_frq,
    input  wire                   i_left_take,
    input  wire [SYMBOL_BITS-1:0] i_left_sym,
    input  wire [FREQ_BITS-1:0]   i_left_frq,
    input  wire [SYMBOL_BITS-1:0] i_right_sym,
    input  wire [FREQ_BITS-1:0]   i_right_frq,
    output logic                  o_take,
    output logic [SYMBOL_BITS-1:0] o_sym,
    output logic [FREQ_BITS-1:0]  o_frq
);
    import sfpq_pkg::*;

    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic [FREQ_BITS-1:0]   r_frq, n_frq;

    // An empty slot, or one whose key is not below the new key, yields its
    // place. Along a sorted chain this flag rises once and stays high.
    assign o_take = !i_occ || (r_frq >= i_new_frq);

    always_comb begin
        n_sym = r_sym;
        n_frq = r_frq;
        if (i_cmd.ins) begin
            if (i_left_take) begin
                n_sym = i_left_sym;
                n_frq = i_left_frq;
            end else if (o_take) begin
                n_sym = i_new_sym;
                n_frq = i_new_frq;
            end
        end else if (i_cmd.rem) begin
            n_sym = i_right_sym;
            n_frq = i_right_frq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_frq <= n_frq;
    end

    assign o_sym = r_sym;
    assign o_frq = r_frq;
endmodule
`default_nettype wire

@@ design/sorted_frequency_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_frequency_priority_queue
// Priority queue of (symbol, frequency) entries kept in ascending order of
// frequency in a shift-register chain of cells.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat carries
//  i_cmd     in         kind, new_symbol, new_frequency
//  o_res     out        status, out_symbol, out_frequency, entry_count, list_empty
//
//  One request beat is taken per clock cycle while the result side is not
//  stalled; its result beat is registered and offered in the following cycle.
//  The rate is set by the cell chain, where every cell compares its key with
//  the new key in the same cycle. A request is taken while the result register
//  is empty or being drained, so a stalled result stalls the request side only
//  after one beat waits. Synchronous reset empties the queue and the result
//  register; the entry storage itself is not cleared and needs no clearing pass.
//
module sorted_frequency_priority_queue #(
    parameter int QUEUE_DEPTH = sfpq_pkg::QUEUE_DEPTH_DEF,
    parameter int SYMBOL_BITS = sfpq_pkg::SYMBOL_BITS_DEF,
    parameter int FREQ_BITS   = sfpq_pkg::FREQ_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sfpq_in_if.sink    i_cmd,
    sfpq_out_if.source o_res
);
    import sfpq_pkg::*;

    localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CountBits-1:0] CountFull = CountBits'(QUEUE_DEPTH);

    // Fill count and result register.
    logic [CountBits-1:0]   r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic [SYMBOL_BITS-1:0] r_out_sym, n_out_sym;
    logic [FREQ_BITS-1:0]   r_out_frq, n_out_frq;
    logic [CountBits-1:0]   r_out_count, n_out_count;

    logic      w_accept;
    t_cell_cmd w_cmd;

    logic                   w_take [QUEUE_DEPTH];
    logic [SYMBOL_BITS-1:0] w_sym  [QUEUE_DEPTH];
    logic [FREQ_BITS-1:0]   w_frq  [QUEUE_DEPTH];

    // A new beat is taken whenever the result register can hand over or is free.
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // Inserts into a full queue and removes from an empty one leave the
    // chain untouched.
    assign w_cmd.ins = w_accept && (i_cmd.kind == KIND_INSERT) && (r_count != CountFull);
    assign w_cmd.rem = w_accept && (i_cmd.kind == KIND_REMOVE) && (r_count != '0);

    // The chain: each cell sees the yield flag and entry of its left
    // neighbour and the entry of its right neighbour. The head cell holds the
    // lowest frequency; the tail cell fills with zeros on a remove.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                   w_left_take;
        logic [SYMBOL_BITS-1:0] w_left_sym, w_right_sym;
        logic [FREQ_BITS-1:0]   w_left_frq, w_right_frq;
        logic                   w_occ;

        assign w_occ = CountBits'(g) < r_count;

        if (g == 0) begin : g_head
            assign w_left_take = 1'b0;
            assign w_left_sym  = '0;
            assign w_left_frq  = '0;
        end else begin : g_mid
            assign w_left_take = w_take[g-1];
            assign w_left_sym  = w_sym[g-1];
            assign w_left_frq  = w_frq[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right_sym = '0;
            assign w_right_frq = '0;
        end else begin : g_body
            assign w_right_sym = w_sym[g+1];
            assign w_right_frq = w_frq[g+1];
        end

        sfpq_cell #(
            .SYMBOL_BITS (SYMBOL_BITS),
            .FREQ_BITS   (FREQ_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occ       (w_occ),
            .i_new_sym   (i_cmd.new_symbol),
            .i_new_frq   (i_cmd.new_frequency),
            .i_left_take (w_left_take),
            .i_left_sym  (w_left_sym),
            .i_left_frq  (w_left_frq),
            .i_right_sym (w_right_sym),
            .i_right_frq (w_right_frq),
            .o_take      (w_take[g]),
            .o_sym       (w_sym[g]),
            .o_frq       (w_frq[g])
        );
    end

    // Next fill count and result beat.
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out_sym   = r_out_sym;
        n_out_frq   = r_out_frq;
        n_out_count = r_out_count;

        if (w_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.rem) begin
            n_count = r_count - 1'b1;
        end

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_count = n_count;
            n_out_sym   = '0;
            n_out_frq   = '0;
            if (w_cmd.rem) begin
                n_status  = ST_OK;
                n_out_sym = w_sym[0];
                n_out_frq = w_frq[0];
            end else if (w_cmd.ins) begin
                n_status = ST_OK;
            end else if (i_cmd.kind == KIND_REMOVE) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_status    <= n_status;
        r_out_sym   <= n_out_sym;
        r_out_frq   <= n_out_frq;
        r_out_count <= n_out_count;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.out_symbol    = r_out_sym;
    assign o_res.out_frequency = r_out_frq;
    assign o_res.entry_count   = r_out_count;
    assign o_res.list_empty    = (r_out_count == '0);

    // The fill count never goes beyond the depth of the chain.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountFull)
        else $error("fill count beyond queue depth");

    // The two lowest entries held stay in ascending order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CountBits'(2)) |-> (w_frq[0] <= w_frq[1]))
        else $error("head entries out of order");

    // A result beat reports the fill count that the queue then holds.
    a_count_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_res.entry_count == r_count))
        else $error("reported count differs from fill count");

    // A removed beat carries the entry that sat at the head.
    a_remove_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rem |=> (o_res.out_frequency == $past(w_frq[0])))
        else $error("removed entry is not the former head");
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted frequency priority queue. A short table
// of directed beats covers the field extremes, both operations, ties in
// frequency, a full queue and an empty queue. Random beats follow, biased
// in turn towards filling and draining the queue. Each result beat is
// checked against its table row or a behavioural bench copy of the queue.
// ----------------------------------------------------------------------------
module tb;
    import sfpq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int SYM_W       = SYMBOL_BITS_DEF;
    localparam int FRQ_W       = FREQ_BITS_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_BEATS = 1500;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SHOWN_ERRORS = 10;
    localparam bit TYPED        = 1'b1;
    localparam bit PREDICTED    = 1'b0;
    localparam logic [FRQ_W-1:0] FRQ_MAX = '1;

    typedef struct packed {
        t_status          status;
        logic [SYM_W-1:0] sym;
        logic [FRQ_W-1:0] frq;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_pq_result;

    // One request beat; the expected result is only meaningful when typed.
    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] sym;
        logic [FRQ_W-1:0] frq;
        bit               typed;
        t_pq_result       res;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    sfpq_in_if  #(.SYMBOL_BITS(SYM_W), .FREQ_BITS(FRQ_W)) cmd_if ();
    sfpq_out_if #(.SYMBOL_BITS(SYM_W), .FREQ_BITS(FRQ_W), .COUNT_BITS(CNT_W)) res_if ();

    sorted_frequency_priority_queue #(
        .QUEUE_DEPTH (DEPTH),
        .SYMBOL_BITS (SYM_W),
        .FREQ_BITS   (FRQ_W)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Bench copy of the queue contents, lowest frequency at index 0.
    logic [SYM_W-1:0] held_sym [DEPTH];
    logic [FRQ_W-1:0] held_frq [DEPTH];
    int               held_entries;

    t_pq_result pending_results [$];
    t_pq_result oldest_result;
    int         error_count;
    int         cycle_count;
    int         send_calm;
    int         take_calm;

    // Directed beats: the rows marked TYPED carry a result that is obvious
    // from the queue state, the rest are checked against the bench queue.
    t_stim_row directed_rows [25] = '{
        '{KIND_REMOVE, 9'h000, 24'h000000, TYPED, '{ST_EMPTY, 9'h000, 24'h0, 5'd0, 1'b1}},
        '{KIND_INSERT, 9'h1FF, 24'hFFFFFF, TYPED, '{ST_OK, 9'h000, 24'h0, 5'd1, 1'b0}},
        '{KIND_INSERT, 9'h000, 24'h000000, TYPED, '{ST_OK, 9'h000, 24'h0, 5'd2, 1'b0}},
        '{KIND_REMOVE, 9'h1FF, 24'hFFFFFF, TYPED, '{ST_OK, 9'h000, 24'h0, 5'd1, 1'b0}},
        '{KIND_REMOVE, 9'h000, 24'h000000, TYPED,
          '{ST_OK, 9'h1FF, 24'hFFFFFF, 5'd0, 1'b1}},
        '{KIND_REMOVE, 9'h0AA, 24'h555555, TYPED, '{ST_EMPTY, 9'h000, 24'h0, 5'd0, 1'b1}},
        '{KIND_INSERT, 9'h005, 24'd100, PREDICTED, '0},
        '{KIND_INSERT, 9'h006, 24'd100, PREDICTED, '0},
        '{KIND_INSERT, 9'h007, 24'd50, PREDICTED, '0},
        '{KIND_INSERT, 9'h155, 24'hAAAAAA, PREDICTED, '0},
        '{KIND_INSERT, 9'h0AA, 24'h555555, PREDICTED, '0},
        '{KIND_INSERT, 9'h1FF, 24'h000000, PREDICTED, '0},
        '{KIND_INSERT, 9'h000, 24'hFFFFFF, PREDICTED, '0},
        '{KIND_INSERT, 9'h100, 24'h800000, PREDICTED, '0},
        '{KIND_INSERT, 9'h0FF, 24'h7FFFFF, PREDICTED, '0},
        '{KIND_INSERT, 9'h001, 24'd1, PREDICTED, '0},
        '{KIND_INSERT, 9'h002, 24'd100, PREDICTED, '0},
        '{KIND_INSERT, 9'h003, 24'd50, PREDICTED, '0},
        '{KIND_INSERT, 9'h004, 24'hFFFFFF, PREDICTED, '0},
        '{KIND_INSERT, 9'h008, 24'h000000, PREDICTED, '0},
        '{KIND_INSERT, 9'h009, 24'h123456, PREDICTED, '0},
        '{KIND_INSERT, 9'h00A, 24'd101, PREDICTED, '0},
        '{KIND_INSERT, 9'h1AB, 24'h000000, TYPED, '{ST_FULL, 9'h000, 24'h0, 5'd16, 1'b0}},
        '{KIND_REMOVE, 9'h155, 24'hAAAAAA, PREDICTED, '0},
        '{KIND_INSERT, 9'h1CD, 24'hFFFFFE, PREDICTED, '0}
    };

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Works out the result of one accepted request and updates the queue.
    function automatic t_pq_result predict_queue_step(logic kind, logic [SYM_W-1:0] sym,
                                                      logic [FRQ_W-1:0] frq);
        t_pq_result r;
        int         pos;
        r = '{ST_OK, '0, '0, '0, 1'b0};
        if (kind == KIND_REMOVE) begin
            if (held_entries == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.sym = held_sym[0];
                r.frq = held_frq[0];
                for (int i = 1; i < held_entries; i++) begin
                    held_sym[i-1] = held_sym[i];
                    held_frq[i-1] = held_frq[i];
                end
                held_entries--;
            end
        end else if (held_entries >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            // The new entry goes in front of the first one that is not lower,
            // so the newest of several equal frequencies leaves first.
            pos = held_entries;
            for (int i = 0; i < held_entries; i++) begin
                if (held_frq[i] >= frq) begin
                    pos = i;
                    break;
                end
            end
            for (int i = held_entries; i > pos; i--) begin
                held_sym[i] = held_sym[i-1];
                held_frq[i] = held_frq[i-1];
            end
            held_sym[pos] = sym;
            held_frq[pos] = frq;
            held_entries++;
        end
        r.count = CNT_W'(held_entries);
        r.empty = (held_entries == 0);
        return r;
    endfunction

    // Idle cycles before the next beat, with occasional runs of none at all.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Presents one request beat and records its expected result on acceptance.
    // Entered and left on a rising edge.
    task automatic send_beat(input t_stim_row row);
        int         gap;
        t_pq_result want;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.kind          <= row.kind;
        cmd_if.new_symbol    <= row.sym;
        cmd_if.new_frequency <= row.frq;
        do @(posedge clk); while (!cmd_if.ready);
        want = predict_queue_step(row.kind, row.sym, row.frq);
        if (row.typed) begin
            want = row.res;
        end
        pending_results.push_back(want);
    endtask

    // Holds the request side back until every outstanding result has come.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
    endtask

    // Result side: random stalls on ready, one draw per beat.
    initial begin
        int stall;
        res_if.ready = 1'b0;
        take_calm    = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= SHOWN_ERRORS) begin
                    $display("[%0t] result beat with nothing expected: status %0d sym %h",
                             $realtime, res_if.status, res_if.out_symbol);
                end
            end else begin
                oldest_result = pending_results.pop_front();
                if (res_if.status !== oldest_result.status
                        || res_if.out_symbol !== oldest_result.sym
                        || res_if.out_frequency !== oldest_result.frq
                        || res_if.entry_count !== oldest_result.count
                        || res_if.list_empty !== oldest_result.empty) begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS) begin
                        $display("[%0t] mismatch: expected st %0d sym %h frq %h cnt %0d emp %0b",
                                 $realtime, oldest_result.status, oldest_result.sym,
                                 oldest_result.frq, oldest_result.count, oldest_result.empty);
                        $display("[%0t]           actual   st %0d sym %h frq %h cnt %0d emp %0b",
                                 $realtime, res_if.status, res_if.out_symbol,
                                 res_if.out_frequency, res_if.entry_count, res_if.list_empty);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** sorted_frequency_priority_queue: FAILED **");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        int        insert_pct;
        rst_n                = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.kind          = KIND_INSERT;
        cmd_if.new_symbol    = '0;
        cmd_if.new_frequency = '0;
        held_entries         = 0;
        error_count          = 0;
        cycle_count          = 0;
        send_calm            = 0;
        insert_pct           = 50;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n]) begin
            send_beat(directed_rows[n]);
        end
        drain_results();

        // Random part. The insert share swings between phases so the queue
        // fills up to the full case and drains down to the empty case.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 120 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 25;
                    default: insert_pct = 55;
                endcase
            end
            if (n % 400 == 399) begin
                drain_results();
            end
            row       = '0;
            row.typed = PREDICTED;
            row.kind  = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            row.sym   = SYM_W'($urandom_range(0, (1 << SYM_W) - 1));
            // Narrow ranges give many ties; the rest spans the whole key.
            case ($urandom_range(0, 5))
                0:       row.frq = '0;
                1:       row.frq = FRQ_MAX;
                2:       row.frq = FRQ_W'($urandom_range(0, 7));
                3:       row.frq = FRQ_W'($urandom_range(0, 63));
                default: row.frq = FRQ_W'($urandom);
            endcase
            send_beat(row);
        end

        cmd_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        // Wait on so that any stray result beat is caught.
        repeat (20) @(posedge clk);
        if (error_count == 0) begin
            $display("** sorted_frequency_priority_queue: PASSED **");
        end else begin
            $display("** sorted_frequency_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule

@@ sorted_frequency_priority_queue.f @@
design/sfpq_pkg.sv
design/sfpq_in_if.sv
design/sfpq_out_if.sv
design/sfpq_cell.sv
design/sorted_frequency_priority_queue.sv
bench/tb.sv
